// File: hdl/lesf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared types, widths and register codes of the largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

  localparam int unsigned MaxColsDef = 1024;
  localparam int unsigned MaxRowsDef = 1024;

  localparam int CharW     = 8;
  localparam int WidthRegW = 11;
  localparam int SizeW     = 11;
  localparam int PosW      = 10;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EMPTY_CHAR = 1'b0,
    REG_ROW_WIDTH  = 1'b1
  } cfg_reg_e;

  localparam logic [CharW-1:0]     EmptyCharRst = 8'd46;
  localparam logic [WidthRegW-1:0] RowWidthRst  = 11'd1024;

  typedef logic [SizeW-1:0] size_t;

  // control bits of the second pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
    logic row_end;
    logic row_nz;
    logic fwd;
    logic empty;
  } s1_ctrl_t;

  function automatic size_t min3(input size_t a, input size_t b, input size_t c);
    size_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

// File: hdl/lesf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_cell_if / lesf_result_if
// Valid/ready channels for grid cells in and square results out.
// ----------------------------------------------------------------------------
interface lesf_cell_if;
  logic                      valid;
  logic                      ready;
  logic [lesf_pkg::CharW-1:0] cell_req;
  logic                      last_cell;

  modport source (output valid, output cell_req, output last_cell, input ready);
  modport sink   (input valid, input cell_req, input last_cell, output ready);
endinterface

interface lesf_result_if;
  logic                      valid;
  logic                      ready;
  logic [lesf_pkg::SizeW-1:0] square_size;
  logic [lesf_pkg::PosW-1:0]  top_row;
  logic [lesf_pkg::PosW-1:0]  left_col;

  modport source (output valid, output square_size, output top_row, output left_col,
                  input ready);
  modport sink   (input valid, input square_size, input top_row, input left_col,
                  output ready);
endinterface

// File: hdl/largest_empty_square_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Streams a grid in raster order and reports its largest all-empty square.
// ----------------------------------------------------------------------------
// Cells come in on cell_in, one byte per transfer in row-major order; the
// row width and the empty byte sit in two config registers, which the user
// writes through cfg_we_i / cfg_idx_i / cfg_data_i only while the block is
// idle (the block does not enforce this). The transfer flagged last_cell
// closes the grid: one result (size, top row, left column of the top-left
// corner, first in raster order on ties) goes out on result_out, and the
// next transfer starts a new grid. One cell per cycle unless a last cell
// waits on a stalled result (below). Each cell takes one line-memory read in
// the first stage and one minimum-plus-one step and write-back in the
// second; a same-column write/read pair (one-cell rows) is forwarded.
// The output register holds a result while the receiver stalls and cells
// keep flowing; only a second last cell waits until the first result
// is taken.
// Reset loads the config defaults and clears counters and the running
// best; the line memory is not cleared, since the first row never reads it.
// ----------------------------------------------------------------------------
module largest_empty_square_finder #(
  parameter int unsigned MAX_COLS = lesf_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = lesf_pkg::MaxRowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lesf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lesf_pkg::CfgDataW-1:0] cfg_data_i,
  lesf_cell_if.sink                     cell_in,
  lesf_result_if.source                 result_out
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WdC   = $clog2(MAX_COLS + 1);
  localparam int WdW   = (WdC > lesf_pkg::WidthRegW) ? WdC : lesf_pkg::WidthRegW;
  localparam int MW0   = (RW > CW) ? RW : CW;
  localparam int MW    = (MW0 > lesf_pkg::SizeW) ? MW0 : lesf_pkg::SizeW;
  localparam int BW    = MW + 1;
  localparam int SizeW = lesf_pkg::SizeW;
  localparam int PosW  = lesf_pkg::PosW;

  // config registers
  logic [lesf_pkg::CharW-1:0]     empty_char_q;
  logic [lesf_pkg::WidthRegW-1:0] row_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_char_q <= lesf_pkg::EmptyCharRst;
      row_width_q  <= lesf_pkg::RowWidthRst;
    end else if (cfg_we_i) begin
      unique case (lesf_pkg::cfg_reg_e'(cfg_idx_i))
        lesf_pkg::REG_EMPTY_CHAR: empty_char_q <= cfg_data_i[lesf_pkg::CharW-1:0];
        lesf_pkg::REG_ROW_WIDTH:  row_width_q  <= cfg_data_i[lesf_pkg::WidthRegW-1:0];
        default: ;
      endcase
    end
  end

  // effective row width, clamped to 1..MAX_COLS
  logic [WdW-1:0] width_ext, width_eff;
  assign width_ext = WdW'(row_width_q);

  always_comb begin
    if (width_ext == '0) begin
      width_eff = WdW'(1);
    end else if (width_ext > WdW'(MAX_COLS)) begin
      width_eff = WdW'(MAX_COLS);
    end else begin
      width_eff = width_ext;
    end
  end

  // stage 0: raster counters and line-memory read
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          row_end0;
  logic          accept, stall, s1_fire;

  lesf_pkg::s1_ctrl_t s1_q, s1_d;
  logic [CW-1:0]      s1_col_q;
  logic [RW-1:0]      s1_row_q;
  logic [SizeW-1:0]   up_rd_q, fwd_val_q;
  logic [SizeW-1:0]   line_mem [MAX_COLS];

  logic [SizeW-1:0] left_q, diag_q, best_size_q;
  logic [PosW-1:0]  best_row_q, best_col_q;
  logic             out_valid_q;
  logic [SizeW-1:0] out_size_q;
  logic [PosW-1:0]  out_row_q, out_col_q;

  logic [SizeW-1:0] up, val;
  logic             better;
  logic [BW-1:0]    row_ext, col_ext, val_ext;
  logic [PosW-1:0]  cand_row, cand_col;
  logic [SizeW-1:0] best_size_nxt;
  logic [PosW-1:0]  best_row_nxt, best_col_nxt;

  assign row_end0 = (WdW'(col_q) + WdW'(1)) >= width_eff;
  assign stall    = s1_q.valid & s1_q.last & out_valid_q & ~result_out.ready;
  assign s1_fire  = s1_q.valid & ~stall;
  assign accept   = cell_in.valid & cell_in.ready;
  assign cell_in.ready = ~stall;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (cell_in.last_cell) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end0) begin
        col_d = '0;
        if (row_q != RW'(MAX_ROWS - 1)) begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    s1_d = s1_q;
    if (accept) begin
      s1_d.valid   = 1'b1;
      s1_d.last    = cell_in.last_cell;
      s1_d.row_end = row_end0;
      s1_d.row_nz  = (row_q != '0);
      // the write of the item ahead lands at this same edge
      s1_d.fwd     = s1_fire & (s1_col_q == col_q);
      s1_d.empty   = (cell_in.cell_req == empty_char_q);
    end else if (s1_fire) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      fwd_val_q <= val;
    end
  end

  // line memory: at most one write-back and one read per cycle
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_col_q] <= val;
    end
    if (accept) begin
      up_rd_q <= line_mem[col_q];
    end
  end

  // stage 1: minimum-plus-one recurrence and running best
  always_comb begin
    if (!s1_q.row_nz) begin
      up = '0;
    end else if (s1_q.fwd) begin
      up = fwd_val_q;
    end else begin
      up = up_rd_q;
    end
    val = s1_q.empty ? (lesf_pkg::min3(left_q, up, diag_q) + SizeW'(1)) : '0;
    better  = val > best_size_q;
    row_ext = BW'(s1_row_q) + BW'(1);
    col_ext = BW'(s1_col_q) + BW'(1);
    val_ext = BW'(val);
    cand_row = (row_ext >= val_ext) ? PosW'(row_ext - val_ext) : '0;
    cand_col = (col_ext >= val_ext) ? PosW'(col_ext - val_ext) : '0;
    best_size_nxt = better ? val      : best_size_q;
    best_row_nxt  = better ? cand_row : best_row_q;
    best_col_nxt  = better ? cand_col : best_col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (s1_fire) begin
      if (s1_q.last) begin
        left_q      <= '0;
        diag_q      <= '0;
        best_size_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        left_q      <= s1_q.row_end ? '0 : val;
        diag_q      <= s1_q.row_end ? '0 : up;
        best_size_q <= best_size_nxt;
        best_row_q  <= best_row_nxt;
        best_col_q  <= best_col_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_q.last) begin
      out_valid_q <= 1'b1;
    end else if (result_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.last) begin
      out_size_q <= best_size_nxt;
      out_row_q  <= best_row_nxt;
      out_col_q  <= best_col_nxt;
    end
  end

  assign result_out.valid       = out_valid_q;
  assign result_out.square_size = out_size_q;
  assign result_out.top_row     = out_row_q;
  assign result_out.left_col    = out_col_q;

endmodule

// File: hdl/lesf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_checker
// Port-level assertions for the largest empty square finder, bound to it.
// ----------------------------------------------------------------------------
module lesf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [lesf_pkg::SizeW-1:0] out_size_i,
  input logic [lesf_pkg::PosW-1:0]  out_row_i,
  input logic [lesf_pkg::PosW-1:0]  out_col_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({out_size_i, out_row_i, out_col_i}))
    else $error("result changed while stalled");

  // last-cell transfer yields a visible result
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |-> ##2 out_valid_i)
    else $error("no result after last cell");

  // no square means no location
  a_zero_loc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_size_i == '0) |-> (out_row_i == '0) && (out_col_i == '0))
    else $error("empty result carries a location");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cell_in.valid),
  .in_ready_i  (cell_in.ready),
  .in_last_i   (cell_in.last_cell),
  .out_valid_i (result_out.valid),
  .out_ready_i (result_out.ready),
  .out_size_i  (result_out.square_size),
  .out_row_i   (result_out.top_row),
  .out_col_i   (result_out.left_col)
);
